// File: hw/rtl/assert_macros.svh
// Assertion macros used by the top RTL file of the priority queue.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every clock edge outside reset.
`define BPQ_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Condition that must hold in the cycle after the trigger.
`define BPQ_ASSERT_NEXT(lbl, trig, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cons)) \
		else $error(msg);

`endif

// File: hw/rtl/bpq_pkg.sv
// Shared types, codes and sizes of the bounded priority queue.
package bpq_pkg;
	localparam int CAPACITY    = 8;
	localparam int CNT_W       = $clog2(CAPACITY + 1);
	localparam int OP_W        = 2;
	localparam int PRIO_W      = 8;
	localparam int DATA_W      = 32;
	localparam int STATUS_W    = 2;
	localparam int COUNT_OUT_W = 4;

	localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
	localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
	localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

	localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

	typedef struct packed {
		logic [PRIO_W-1:0]        prio;
		logic signed [DATA_W-1:0] data;
	} entry_t;

	typedef enum logic [1:0] {
		CMD_HOLD,
		CMD_INSERT,
		CMD_REMOVE
	} cmd_t;

	typedef struct packed {
		cmd_t   cmd;
		entry_t new_ent;
	} cell_ctl_t;
endpackage

// File: hw/rtl/bpq_in_if.sv
// Operation channel of the priority queue.
interface bpq_in_if;
	logic                                valid;
	logic                                ready;
	logic [bpq_pkg::OP_W-1:0]            op;
	logic [bpq_pkg::PRIO_W-1:0]          in_priority;
	logic signed [bpq_pkg::DATA_W-1:0]   in_data;

	modport source (output valid, op, in_priority, in_data, input ready);
	modport sink (input valid, op, in_priority, in_data, output ready);
endinterface

// File: hw/rtl/bpq_out_if.sv
// Result channel of the priority queue.
interface bpq_out_if;
	logic                                 valid;
	logic                                 ready;
	logic [bpq_pkg::STATUS_W-1:0]         status;
	logic signed [bpq_pkg::DATA_W-1:0]    out_data;
	logic [bpq_pkg::PRIO_W-1:0]           out_priority;
	logic [bpq_pkg::COUNT_OUT_W-1:0]      count;

	modport source (output valid, status, out_data, out_priority, count, input ready);
	modport sink (input valid, status, out_data, out_priority, count, output ready);
endinterface

// File: hw/rtl/bpq_cell.sv
// One slot of the sorted entry chain.
module bpq_cell (
	input  logic               clk,
	input  bpq_pkg::cell_ctl_t ctl,
	input  logic               occupied,
	input  logic               prev_keep,
	input  bpq_pkg::entry_t    prev_ent,
	input  bpq_pkg::entry_t    next_ent,
	output logic               keep,
	output bpq_pkg::entry_t    ent
);
	import bpq_pkg::*;

	entry_t ent_q;
	entry_t ent_nxt;

	// Equal priorities stay ahead of the new item, so the oldest one leaves first.
	assign keep = occupied && (ent_q.prio >= ctl.new_ent.prio);
	assign ent  = ent_q;

	always_comb begin
		ent_nxt = ent_q;
		case (ctl.cmd)
			CMD_INSERT: begin
				if (keep) begin
					ent_nxt = ent_q;
				end else if (prev_keep) begin
					ent_nxt = ctl.new_ent;
				end else begin
					ent_nxt = prev_ent;
				end
			end
			CMD_REMOVE: ent_nxt = next_ent;
			default: ent_nxt = ent_q;
		endcase
	end

	always_ff @(posedge clk) begin
		ent_q <= ent_nxt;
	end
endmodule

// File: hw/rtl/bounded_priority_queue_top.sv
// Bounded priority queue: a chain of cells kept sorted by priority, then age.
//
// in_ch carries one operation per item: insert (op, in_priority, in_data),
// remove the highest priority entry, or clear. out_ch returns exactly one
// result item per operation: status, the removed data and priority (zero
// when nothing was removed) and the entry count after the operation.
// An operation's result is registered and valid on out_ch in the cycle after
// it is taken; one item is accepted every cycle while out_ch is not stalled.
// The cells reorder themselves on each insert by comparing the new priority
// in parallel, so cell zero always holds the entry to remove next.
// The result sits in an output register; in_ch.ready stays high while that
// register is empty or is being emptied. When a result waits and the
// receiver stalls, in_ch.ready drops in that same cycle, so nothing is lost.
// Reset clears the entry count and the result valid flag; the cell
// contents are left as they are and are ignored until written.
module bounded_priority_queue_top (
	input  logic      clk,
	input  logic      arst_n,
	bpq_in_if.sink    in_ch,
	bpq_out_if.source out_ch
);
	import bpq_pkg::*;

	`include "assert_macros.svh"

	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] cnt_nxt;
	logic             out_valid_q;
	logic [STATUS_W-1:0]       status_q;
	logic signed [DATA_W-1:0]  data_q;
	logic [PRIO_W-1:0]         prio_q;
	logic [COUNT_OUT_W-1:0]    count_q;

	logic                accept;
	logic                full;
	logic                empty;
	logic [STATUS_W-1:0] status_nxt;
	entry_t              rem_ent;
	cell_ctl_t           ctl;

	entry_t ent   [CAPACITY];
	logic   keep  [CAPACITY];
	logic   occ   [CAPACITY];

	assign in_ch.ready = !out_valid_q || out_ch.ready;
	assign accept      = in_ch.valid && in_ch.ready;
	assign full        = (cnt_q == CNT_W'(CAPACITY));
	assign empty       = (cnt_q == '0);

	always_comb begin
		ctl.cmd          = CMD_HOLD;
		ctl.new_ent.prio = in_ch.in_priority;
		ctl.new_ent.data = in_ch.in_data;
		cnt_nxt          = cnt_q;
		status_nxt       = ST_DONE;
		rem_ent          = '0;
		case (in_ch.op)
			OP_INSERT: begin
				if (full) begin
					status_nxt = ST_FULL;
				end else begin
					ctl.cmd = CMD_INSERT;
					cnt_nxt = CNT_W'(cnt_q + 1'b1);
				end
			end
			OP_REMOVE: begin
				if (empty) begin
					status_nxt = ST_EMPTY;
				end else begin
					ctl.cmd = CMD_REMOVE;
					rem_ent = ent[0];
					cnt_nxt = CNT_W'(cnt_q - 1'b1);
				end
			end
			OP_CLEAR: cnt_nxt = '0;
			default: cnt_nxt = cnt_q;
		endcase
		if (!accept) begin
			ctl.cmd = CMD_HOLD;
		end
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		entry_t prev_ent;
		entry_t next_ent;
		logic   prev_keep;

		assign occ[i] = (CNT_W'(i) < cnt_q);

		if (i == 0) begin : g_head
			assign prev_ent  = ctl.new_ent;
			assign prev_keep = 1'b1;
		end else begin : g_body
			assign prev_ent  = ent[i-1];
			assign prev_keep = keep[i-1];
		end

		if (i == CAPACITY - 1) begin : g_tail
			assign next_ent = '0;
		end else begin : g_mid
			assign next_ent = ent[i+1];
		end

		bpq_cell u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.occupied  (occ[i]),
			.prev_keep (prev_keep),
			.prev_ent  (prev_ent),
			.next_ent  (next_ent),
			.keep      (keep[i]),
			.ent       (ent[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				cnt_q       <= cnt_nxt;
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_q <= status_nxt;
			data_q   <= rem_ent.data;
			prio_q   <= rem_ent.prio;
			count_q  <= COUNT_OUT_W'(cnt_nxt);
		end
	end

	assign out_ch.valid        = out_valid_q;
	assign out_ch.status       = status_q;
	assign out_ch.out_data     = data_q;
	assign out_ch.out_priority = prio_q;
	assign out_ch.count        = count_q;

	`BPQ_ASSERT_ALWAYS(a_cnt_bound, cnt_q <= CNT_W'(CAPACITY), "entry count above capacity")

	`BPQ_ASSERT_NEXT(a_full_refused, accept && (in_ch.op == OP_INSERT) && full,
		out_valid_q && (status_q == ST_FULL) && $stable(cnt_q), "full insert not refused")

	`BPQ_ASSERT_NEXT(a_clear, accept && (in_ch.op == OP_CLEAR),
		(cnt_q == '0) && (status_q == ST_DONE), "clear left entries")

	for (genvar j = 0; j < CAPACITY - 1; j++) begin : g_chk
		`BPQ_ASSERT_ALWAYS(a_sorted,
			!occ[j+1] || (ent[j].prio >= ent[j+1].prio), "chain out of order")
	end
endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench of the bounded priority queue: directed and random traffic and a built-in predictor.
module testbench;
	import bpq_pkg::*;

	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

	typedef struct packed {
		logic [OP_W-1:0]          op;
		logic [PRIO_W-1:0]        prio;
		logic signed [DATA_W-1:0] data;
	} queue_op_t;

	typedef struct packed {
		logic [STATUS_W-1:0]      status;
		logic signed [DATA_W-1:0] data;
		logic [PRIO_W-1:0]        prio;
		logic [COUNT_OUT_W-1:0]   count;
	} queue_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	bpq_in_if  op_ch ();
	bpq_out_if res_ch ();

	bounded_priority_queue_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (op_ch),
		.out_ch (res_ch)
	);

	queue_op_t     op_backlog[$];
	queue_result_t results_due[$];
	entry_t        held_entries[$];

	logic op_taken;
	logic hold_off;
	logic pressure_go;
	int   send_idle_pct;
	int   sink_stall_pct;

	int err_cnt;
	int checked_cnt;
	int insert_cnt;
	int remove_cnt;
	int clear_cnt;
	int unused_cnt;
	int full_cnt;
	int empty_cnt;

	// Entries are kept oldest first; only a strictly higher priority displaces the
	// current pick, so the oldest of equal priorities leaves first.
	function automatic queue_result_t apply_queue_op(logic [OP_W-1:0] op_code,
			logic [PRIO_W-1:0] ins_prio, logic signed [DATA_W-1:0] ins_data);
		queue_result_t r;
		entry_t        e;
		int            best;
		r.status = ST_DONE;
		r.data   = '0;
		r.prio   = '0;
		case (op_code)
		OP_INSERT: begin
			if (held_entries.size() >= CAPACITY) begin
				r.status = ST_FULL;
			end else begin
				e.prio = ins_prio;
				e.data = ins_data;
				held_entries.push_back(e);
			end
		end
		OP_REMOVE: begin
			if (held_entries.size() == 0) begin
				r.status = ST_EMPTY;
			end else begin
				best = 0;
				for (int i = 1; i < held_entries.size(); i++)
					if (held_entries[i].prio > held_entries[best].prio)
						best = i;
				r.data = held_entries[best].data;
				r.prio = held_entries[best].prio;
				held_entries.delete(best);
			end
		end
		OP_CLEAR: begin
			held_entries.delete();
		end
		default: begin
		end
		endcase
		r.count = COUNT_OUT_W'(held_entries.size());
		return r;
	endfunction

	task automatic push_op(logic [OP_W-1:0] op_code, logic [PRIO_W-1:0] prio,
			logic signed [DATA_W-1:0] data);
		queue_op_t item;
		item.op   = op_code;
		item.prio = prio;
		item.data = data;
		op_backlog.push_back(item);
	endtask

	// Bursts with a varying insert share drive the queue to full and back to empty;
	// narrow priority sets make ties common.
	task automatic add_random_ops(int n_ops);
		int        done_ops;
		int        burst_left;
		int        ins_pct;
		int        prio_mode;
		int        roll;
		logic [OP_W-1:0]   op_code;
		logic [PRIO_W-1:0] prio;
		done_ops   = 0;
		burst_left = 0;
		ins_pct    = 50;
		prio_mode  = 0;
		while (done_ops < n_ops) begin
			if (burst_left == 0) begin
				burst_left = $urandom_range(8, 40);
				ins_pct    = $urandom_range(15, 85);
				prio_mode  = $urandom_range(2);
			end
			burst_left--;
			roll = $urandom_range(99);
			if (roll < 2)
				op_code = OP_UNUSED;
			else if (roll < 5)
				op_code = OP_CLEAR;
			else if (roll < 5 + ins_pct * 95 / 100)
				op_code = OP_INSERT;
			else
				op_code = OP_REMOVE;
			case (prio_mode)
			0: prio = PRIO_W'($urandom_range(255));
			1: prio = PRIO_W'($urandom_range(3));
			default: prio = $urandom_range(1) ? 8'hFF - PRIO_W'($urandom_range(1))
				: PRIO_W'($urandom_range(1));
			endcase
			push_op(op_code, prio, $urandom);
			if (op_code != OP_UNUSED)
				done_ops++;
		end
	endtask

	task automatic wait_drained();
		do
			@(negedge clk);
		while (op_backlog.size() != 0 || op_ch.valid || results_due.size() != 0);
	endtask

	task automatic run_phase(int send_pct, int stall_pct, int n_ops);
		send_idle_pct  = send_pct;
		sink_stall_pct = stall_pct;
		add_random_ops(n_ops);
		wait_drained();
	endtask

	initial begin
		forever #2 clk = ~clk;
	end

	// Operation driver.
	always @(negedge clk) begin
		queue_op_t nxt;
		logic      offer;
		offer = op_ch.valid;
		if (!arst_n) begin
			offer = 1'b0;
		end else if (!op_ch.valid || op_taken) begin
			offer = 1'b0;
			if (op_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				nxt = op_backlog.pop_front();
				offer = 1'b1;
				op_ch.op          <= nxt.op;
				op_ch.in_priority <= nxt.prio;
				op_ch.in_data     <= nxt.data;
			end
		end
		op_ch.valid <= offer;
	end

	// Result receiver.
	always @(negedge clk) begin
		if (!arst_n)
			res_ch.ready <= 1'b0;
		else
			res_ch.ready <= !hold_off && ($urandom_range(99) >= sink_stall_pct);
	end

	// Long receiver hold-off so the result register backs up into the op channel.
	initial begin
		wait (pressure_go);
		@(negedge clk);
		hold_off <= 1'b1;
		repeat (64) @(negedge clk);
		hold_off <= 1'b0;
	end

	// Monitor: check results against the oldest expectation, then predict new items.
	always @(posedge clk) begin
		queue_result_t got;
		queue_result_t want;
		if (!arst_n) begin
			op_taken <= 1'b0;
		end else begin
			op_taken <= op_ch.valid && op_ch.ready;
			if (res_ch.valid === 1'b1 && res_ch.ready) begin
				got.status = res_ch.status;
				got.data   = res_ch.out_data;
				got.prio   = res_ch.out_priority;
				got.count  = res_ch.count;
				if (results_due.size() == 0) begin
					err_cnt++;
					if (err_cnt <= 10)
						$display("%0t: result with nothing expected: status %0d data %h prio %0d count %0d",
							$realtime, got.status, got.data, got.prio, got.count);
				end else begin
					want = results_due.pop_front();
					checked_cnt++;
					if (got.status !== want.status || got.data !== want.data ||
							got.prio !== want.prio || got.count !== want.count) begin
						err_cnt++;
						if (err_cnt <= 10)
							$display("%0t: mismatch: expected status %0d data %h prio %0d count %0d, got status %0d data %h prio %0d count %0d",
								$realtime, want.status, want.data, want.prio, want.count,
								got.status, got.data, got.prio, got.count);
					end
				end
			end
			if (op_ch.valid && op_ch.ready) begin
				want = apply_queue_op(op_ch.op, op_ch.in_priority, op_ch.in_data);
				results_due.push_back(want);
				case (op_ch.op)
				OP_INSERT: insert_cnt++;
				OP_REMOVE: remove_cnt++;
				OP_CLEAR:  clear_cnt++;
				default:   unused_cnt++;
				endcase
				if (want.status == ST_FULL)
					full_cnt++;
				if (want.status == ST_EMPTY)
					empty_cnt++;
			end
		end
	end

	initial begin
		op_ch.valid       = 1'b0;
		op_ch.op          = OP_INSERT;
		op_ch.in_priority = '0;
		op_ch.in_data     = '0;
		res_ch.ready      = 1'b0;
		op_taken          = 1'b0;
		hold_off          = 1'b0;
		pressure_go       = 1'b0;
		send_idle_pct     = 0;
		sink_stall_pct    = 0;
		err_cnt     = 0;
		checked_cnt = 0;
		insert_cnt  = 0;
		remove_cnt  = 0;
		clear_cnt   = 0;
		unused_cnt  = 0;
		full_cnt    = 0;
		empty_cnt   = 0;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;

		// Empty queue: refused remove, unused code, clear with nothing held.
		push_op(OP_REMOVE, 8'h00, 32'sd0);
		push_op(OP_UNUSED, 8'hFF, -32'sd1);
		push_op(OP_CLEAR, 8'h00, 32'sd0);
		// Fill with extreme priorities and data, several ties at the top.
		push_op(OP_INSERT, 8'h00, 32'sh80000000);
		push_op(OP_INSERT, 8'hFF, 32'sh7FFFFFFF);
		push_op(OP_INSERT, 8'h55, -32'sd1);
		push_op(OP_INSERT, 8'hAA, 32'sd0);
		push_op(OP_INSERT, 8'hFF, 32'sd1);
		push_op(OP_INSERT, 8'h55, 32'sd2);
		push_op(OP_INSERT, 8'hFF, 32'sd3);
		push_op(OP_INSERT, 8'h00, 32'sd4);
		// Full queue: refused insert and an unused code.
		push_op(OP_INSERT, 8'hFF, 32'sh5A5A5A5A);
		push_op(OP_UNUSED, 8'h00, 32'sd0);
		// Equal top priorities leave oldest first.
		push_op(OP_REMOVE, 8'h00, 32'sd0);
		push_op(OP_REMOVE, 8'h00, 32'sd0);
		push_op(OP_REMOVE, 8'h00, 32'sd0);
		push_op(OP_INSERT, 8'h55, 32'shA5A5A5A5);
		push_op(OP_REMOVE, 8'h00, 32'sd0);
		push_op(OP_REMOVE, 8'h00, 32'sd0);
		push_op(OP_CLEAR, 8'hFF, -32'sd1);
		push_op(OP_REMOVE, 8'hFF, -32'sd1);
		push_op(OP_INSERT, 8'h01, 32'sd7);
		push_op(OP_REMOVE, 8'h00, 32'sd0);
		wait_drained();

		run_phase(0, 0, 350);
		run_phase(52, 0, 350);
		run_phase(0, 52, 350);
		run_phase(6, 6, 350);
		pressure_go = 1'b1;
		run_phase(0, 0, 350);
		repeat (4) @(negedge clk);

		$display("Checked %0d results: %0d inserts (%0d refused as full), %0d removes (%0d refused as empty),",
			checked_cnt, insert_cnt, full_cnt, remove_cnt, empty_cnt);
		$display("%0d clears and %0d unused codes, under several sender and receiver idle mixes.",
			clear_cnt, unused_cnt);
		if (err_cnt == 0)
			$display("PASS bounded_priority_queue_top");
		else
			$display("FAIL bounded_priority_queue_top");
		$finish;
	end

	initial begin
		#2000000;
		$display("FAIL bounded_priority_queue_top");
		$finish;
	end
endmodule

// File: filelist.f
+incdir+hw/rtl
hw/rtl/bpq_pkg.sv
hw/rtl/bpq_in_if.sv
hw/rtl/bpq_out_if.sv
hw/rtl/bpq_cell.sv
hw/rtl/bounded_priority_queue_top.sv
tb/sv/testbench.sv
